// ===== hw/rtl/tbrl_pkg.sv =====
// Shared widths, constants and control types for the token bucket rate limiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tbrl_pkg;

    localparam int TIME_W   = 63;   // now_time and refill mark
    localparam int PERIOD_W = 30;   // supply_period
    localparam int COUNT_W  = 16;   // bucket_size, token count
    localparam int STEP_W   = 6;    // divider step counter
    localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(TIME_W - 1);

    // APB byte addresses of the config registers
    localparam logic [2:0] ADDR_SUPPLY_PERIOD = 3'h0;
    localparam logic [2:0] ADDR_BUCKET_SIZE   = 3'h4;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture time, form gap, clear divider
        logic div_step;   // one restoring-division step
        logic refill;     // apply refill from quotient / remainder
        logic grant;      // take a token, load the result register
    } t_tbrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;   // current step is the last quotient bit
    } t_tbrl_sts;

endpackage

// ===== hw/rtl/tbrl_ctrl.sv =====
// Sequencer for the token bucket rate limiter: capture, divide, refill, grant.
// Depends on tbrl_pkg.
`timescale 1ns / 1ps

module tbrl_ctrl
    import tbrl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    input  t_tbrl_sts i_sts,
    output t_tbrl_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_REFILL = 2'd2;
    localparam logic [1:0] ST_GRANT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_REFILL;
                end
            end
            ST_REFILL: begin
                o_cmd.refill = 1'b1;
                n_state      = ST_GRANT;
            end
            ST_GRANT: begin
                if (w_slot_free) begin
                    o_cmd.grant = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.grant) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/tbrl_dp.sv =====
// Datapath: refill mark, token count, radix-2 restoring divider, result register.
// Depends on tbrl_pkg; driven by tbrl_ctrl.
`timescale 1ns / 1ps

module tbrl_dp
    import tbrl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_tbrl_cmd           i_cmd,
    output t_tbrl_sts           o_sts,
    input  logic [TIME_W-1:0]   i_now_time,
    input  logic [PERIOD_W-1:0] i_period,      // already forced nonzero
    input  logic [COUNT_W-1:0]  i_bucket_size,
    output logic                o_granted,
    output logic [COUNT_W-1:0]  o_tokens_left
);

    // state
    logic [TIME_W-1:0]   r_mark;
    logic [COUNT_W-1:0]  r_count;
    // per-request work registers
    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_quo;     // gap, shifted out as quotient shifts in
    logic [PERIOD_W-1:0] r_rem;
    logic                r_ge;      // time not before mark
    logic [STEP_W-1:0]   r_step;
    // result
    logic                r_granted;
    logic [COUNT_W-1:0]  r_left;

    logic [TIME_W:0]     w_diff;
    logic [PERIOD_W:0]   w_shift;
    logic [PERIOD_W:0]   w_sub;
    logic                w_qbit;
    logic                w_big;
    logic [COUNT_W:0]    w_sum;
    logic [COUNT_W-1:0]  w_new_count;
    logic                w_do_refill;

    assign w_diff = {1'b0, i_now_time} - {1'b0, r_mark};

    // one division step: remainder stays below period, so the shifted value < 2*period
    assign w_shift = {r_rem, r_quo[TIME_W-1]};
    assign w_sub   = w_shift - {1'b0, i_period};
    assign w_qbit  = !w_sub[PERIOD_W];

    // refill: count = min(count + periods, bucket)
    assign w_big = (|r_quo[TIME_W-1:COUNT_W]) || (r_quo[COUNT_W-1:0] >= i_bucket_size);
    assign w_sum = {1'b0, r_count} + {1'b0, r_quo[COUNT_W-1:0]};
    always_comb begin
        if (w_big || (w_sum > {1'b0, i_bucket_size})) begin
            w_new_count = i_bucket_size;
        end else begin
            w_new_count = w_sum[COUNT_W-1:0];
        end
    end
    // a refill needs a whole period elapsed, i.e. a nonzero quotient
    assign w_do_refill = r_ge && (|r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.refill && w_do_refill) begin
                // mark + periods*period == time - remainder
                r_mark  <= r_time - {{(TIME_W-PERIOD_W){1'b0}}, r_rem};
                r_count <= w_new_count;
            end else if (i_cmd.grant && (r_count != '0)) begin
                r_count <= r_count - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time <= i_now_time;
            r_quo  <= w_diff[TIME_W-1:0];
            r_ge   <= !w_diff[TIME_W];
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[TIME_W-2:0], w_qbit};
            r_rem  <= w_qbit ? w_sub[PERIOD_W-1:0] : w_shift[PERIOD_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.grant) begin
            r_granted <= (r_count != '0);
            r_left    <= (r_count != '0) ? (r_count - COUNT_W'(1)) : '0;
        end
    end

    assign o_sts.div_done = (r_step == DIV_LAST_STEP);
    assign o_granted      = r_granted;
    assign o_tokens_left  = r_left;

endmodule

// ===== hw/rtl/token_bucket_rate_limiter.sv =====
// Token bucket rate limiter top level: stream ports, APB registers, ctrl + datapath.
// Depends on tbrl_pkg, tbrl_ctrl, tbrl_dp.
`timescale 1ns / 1ps

// Each input beat is one request carrying the current time in ns (counting
// from 0 at reset, non-decreasing). The block refills the bucket with one
// token per whole supply_period elapsed since the refill mark, capped at
// bucket_size, advancing the mark by whole periods only so no time is lost;
// it then takes one token if present. Each request yields exactly one output
// beat: granted plus the tokens left. A time before the mark refills nothing.
// A request passes these steps from acceptance to the output beat: capture
// the time and form the gap, 63 steps of the radix-2 restoring divider
// (gap / period, one quotient bit per cycle), a refill step and a grant
// step. The grant step waits as long as the previous result still
// sits unaccepted in the output register, so result back-pressure adds its
// stall cycles on top. A new request is accepted the cycle after the grant,
// while the previous result may still sit in the output register. Registers:
// 0x0 supply_period (30 bits, 0 behaves as 1), 0x4 bucket_size (16 bits).
// Write them only while the block is idle.

module token_bucket_rate_limiter
    import tbrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [62:0] now_time, [63] zero pad
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] granted, [16:1] tokens_left, [23:17] zero
    // APB config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                w_period_zero;
    logic [PERIOD_W-1:0] r_supply_period;
    logic [COUNT_W-1:0]  r_bucket_size;
    logic [PERIOD_W-1:0] w_period_eff;
    logic                w_wr;
    t_tbrl_cmd           w_cmd;
    t_tbrl_sts           w_sts;
    logic                w_granted;
    logic [COUNT_W-1:0]  w_tokens_left;

    // ---- config registers; paddr[2] selects the register
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply_period <= PERIOD_W'(1000000);
            r_bucket_size   <= COUNT_W'(1);
        end else if (w_wr) begin
            if (paddr[2]) begin
                r_bucket_size   <= pwdata[COUNT_W-1:0];
            end else begin
                r_supply_period <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    assign w_period_zero = (r_supply_period == '0);  // zero period acts as 1 ns
    assign w_period_eff  = w_period_zero ? PERIOD_W'(1) : r_supply_period;

    always_comb begin
        if (paddr[2]) begin
            prdata = {{(32-COUNT_W){1'b0}}, r_bucket_size};
        end else begin
            prdata = {{(32-PERIOD_W){1'b0}}, r_supply_period};
        end
    end

    // ---- sequencer
    tbrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // ---- datapath
    tbrl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_now_time    (s_axis_tdata[TIME_W-1:0]),
        .i_period      (w_period_eff),
        .i_bucket_size (r_bucket_size),
        .o_granted     (w_granted),
        .o_tokens_left (w_tokens_left)
    );

    assign m_axis_tdata = {{(24-COUNT_W-1){1'b0}}, w_tokens_left, w_granted};

    // ---- checks

    // a refused beat always reports an empty bucket
    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[16:1] == 16'd0))
        else $error("refused result with nonzero tokens_left");

    // only one request in flight: accepting one drops ready
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready held after accepting a request");

    // a new result appears exactly as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result produced outside the grant step");

endmodule
